@@ rtl/core/tfn_pkg.sv @@
// Shared widths and pipeline types for the triangle face normal core.
`default_nettype none
package tfn_pkg;
  // Vertex coordinate format (Q3.12)
  localparam int CW = 16;
  // Edge vector component
  localparam int EW = CW + 1;
  // One partial product of the cross product
  localparam int PW = 2 * EW;
  // Cross product component
  localparam int NW = PW + 1;
  // Squared component and squared length
  localparam int SQW = 68;
  localparam int SW = 68;
  // Threshold register
  localparam int THW = 16;
  // Normal fraction bits (Q1.14) and output width
  localparam int NF = 14;
  localparam int OW = 16;
  // Root digits: floor(2^(NF+1) * |n_i| / |n|) lies in 0 .. 2^(NF+1)
  localparam int QW = NF + 2;
  localparam int ROOT_STEPS = QW;
  // Numerator scale and remainder width
  localparam int SHIFT = 2 * NF + 2;
  localparam int RW = 100;
  localparam logic [THW-1:0] THRESH_RESET = 16'd17;

  // One component lane of the digit recurrence
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] ts;
    logic [QW-1:0] q;
    logic          neg;
  } lane_t;

  // Item state carried through the root stages
  typedef struct packed {
    lane_t [2:0]   lane;
    logic [SW-1:0] s;
    logic          deg;
  } root_t;
endpackage
`default_nettype wire

@@ rtl/core/tfn_edge_cross.sv @@
// Edge vectors and exact cross product, three register stages.
`default_nettype none
module tfn_edge_cross
  import tfn_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 ce,
  input  wire                 in_valid,
  input  wire signed [CW-1:0] a_x,
  input  wire signed [CW-1:0] a_y,
  input  wire signed [CW-1:0] a_z,
  input  wire signed [CW-1:0] b_x,
  input  wire signed [CW-1:0] b_y,
  input  wire signed [CW-1:0] b_z,
  input  wire signed [CW-1:0] c_x,
  input  wire signed [CW-1:0] c_y,
  input  wire signed [CW-1:0] c_z,
  output logic                out_valid,
  output logic signed [NW-1:0] n_x,
  output logic signed [NW-1:0] n_y,
  output logic signed [NW-1:0] n_z
);
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] p [3];
  logic signed [PW-1:0] q [3];
  logic [1:0] v;

  // Stage 1: edges b-a and c-a
  always_ff @(posedge clk) begin
    if (ce) begin
      e1[0] <= EW'(b_x) - EW'(a_x);
      e1[1] <= EW'(b_y) - EW'(a_y);
      e1[2] <= EW'(b_z) - EW'(a_z);
      e2[0] <= EW'(c_x) - EW'(a_x);
      e2[1] <= EW'(c_y) - EW'(a_y);
      e2[2] <= EW'(c_z) - EW'(a_z);
    end
  end

  // Stage 2: the six partial products
  always_ff @(posedge clk) begin
    if (ce) begin
      p[0] <= e1[1] * e2[2];
      q[0] <= e1[2] * e2[1];
      p[1] <= e1[2] * e2[0];
      q[1] <= e1[0] * e2[2];
      p[2] <= e1[0] * e2[1];
      q[2] <= e1[1] * e2[0];
    end
  end

  // Stage 3: cross product components
  always_ff @(posedge clk) begin
    if (ce) begin
      n_x <= NW'(p[0]) - NW'(q[0]);
      n_y <= NW'(p[1]) - NW'(q[1]);
      n_z <= NW'(p[2]) - NW'(q[2]);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v <= {v[0], in_valid};
      out_valid <= v[1];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tfn_norm_sq.sv @@
// Squared length, threshold test and root recurrence setup, two stages.
`default_nettype none
module tfn_norm_sq
  import tfn_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  ce,
  input  wire                  in_valid,
  input  wire signed [NW-1:0]  n_x,
  input  wire signed [NW-1:0]  n_y,
  input  wire signed [NW-1:0]  n_z,
  input  wire [THW-1:0]        thresh,
  output logic                 out_valid,
  output root_t                out_data
);
  logic [SQW-1:0] sq [3];
  logic [2:0] neg;
  logic [2*THW-1:0] th_sq;
  logic v;
  logic [SW-1:0] s_sum;

  // Stage A: squares of each component, squared threshold
  always_ff @(posedge clk) begin
    if (ce) begin
      sq[0] <= SQW'(n_x * n_x);
      sq[1] <= SQW'(n_y * n_y);
      sq[2] <= SQW'(n_z * n_z);
      neg <= {n_z[NW-1], n_y[NW-1], n_x[NW-1]};
      th_sq <= thresh * thresh;
    end
  end

  assign s_sum = sq[0] + sq[1] + sq[2];

  // Stage B: length test and lane init (remainder = n_i^2 * 2^SHIFT)
  always_ff @(posedge clk) begin
    if (ce) begin
      out_data.s <= s_sum;
      out_data.deg <= s_sum <= SW'(th_sq);
      for (int i = 0; i < 3; i++) begin
        out_data.lane[i].rem <= RW'(sq[i]) << SHIFT;
        out_data.lane[i].ts <= '0;
        out_data.lane[i].q <= '0;
        out_data.lane[i].neg <= neg[i];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v <= in_valid;
      out_valid <= v;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tfn_root_step.sv @@
// One digit of floor(sqrt(n_i^2 * 2^SHIFT / s)) for all three lanes.
`default_nettype none
module tfn_root_step
  import tfn_pkg::*;
#(
  parameter int K = 0
) (
  input  wire    clk,
  input  wire    rst,
  input  wire    ce,
  input  wire    in_valid,
  input  root_t  in_data,
  output logic   out_valid,
  output root_t  out_data
);
  logic [RW:0] delta [3];
  logic [RW-1:0] s_wide;
  root_t nxt;

  assign s_wide = RW'(in_data.s);

  // Trial digit: (t + 2^K)^2 s - t^2 s = 2^(K+1) t s + 4^K s
  always_comb begin
    nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      delta[i] = ({1'b0, in_data.lane[i].ts} << (K + 1))
               + ({1'b0, s_wide} << (2 * K));
      if ({1'b0, in_data.lane[i].rem} >= delta[i]) begin
        nxt.lane[i].rem = in_data.lane[i].rem - RW'(delta[i]);
        nxt.lane[i].ts = in_data.lane[i].ts + (s_wide << K);
        nxt.lane[i].q = in_data.lane[i].q | (QW'(1) << K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) out_data <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/triangle_face_normal_core.sv @@
// Top level: triangle face normal pipeline with stream ports.
// Pipeline: 3 cross product stages, 2 length stages, 16 root digit stages
//   and 1 output register lie between input accept and output valid.
// Throughput: one triangle per cycle; the whole pipeline holds only while
//   a result sits in the output register and is not taken.
// Reset: rst (synchronous) empties the pipeline and sets the threshold to 17.
`default_nettype none
module triangle_face_normal_core
  import tfn_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, from bit 0)
  input  wire [143:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // normal_x, normal_y, normal_z (16 bits each, from bit 0)
  output logic [47:0] m_tdata,
  // degenerate
  output logic        m_tuser,
  input  wire         cfg_we,
  input  wire [15:0]  cfg_data
);
  logic ce;
  logic [THW-1:0] thresh;
  logic x_valid;
  logic signed [NW-1:0] n_x, n_y, n_z;
  logic r_valid [ROOT_STEPS+1];
  root_t r_data [ROOT_STEPS+1];
  root_t fin;
  logic [QW-1:0] mag [3];
  logic [OW-1:0] comp [3];

  // Pipeline advances unless the output holds an untaken result
  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh <= cfg_data;
    end
  end

  tfn_edge_cross u_cross (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(s_tvalid),
    .a_x(s_tdata[15:0]), .a_y(s_tdata[31:16]), .a_z(s_tdata[47:32]),
    .b_x(s_tdata[63:48]), .b_y(s_tdata[79:64]), .b_z(s_tdata[95:80]),
    .c_x(s_tdata[111:96]), .c_y(s_tdata[127:112]), .c_z(s_tdata[143:128]),
    .out_valid(x_valid), .n_x(n_x), .n_y(n_y), .n_z(n_z)
  );

  tfn_norm_sq u_norm (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(x_valid),
    .n_x(n_x), .n_y(n_y), .n_z(n_z), .thresh(thresh),
    .out_valid(r_valid[0]), .out_data(r_data[0])
  );

  // Root digits, most significant first
  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    tfn_root_step #(.K(ROOT_STEPS - 1 - g)) u_step (
      .clk(clk), .rst(rst), .ce(ce),
      .in_valid(r_valid[g]), .in_data(r_data[g]),
      .out_valid(r_valid[g+1]), .out_data(r_data[g+1])
    );
  end

  assign fin = r_data[ROOT_STEPS];

  // Round half away: m = (t + 1) / 2, then apply sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = (fin.lane[i].q + QW'(1)) >> 1;
      comp[i] = fin.lane[i].neg ? OW'(-mag[i]) : OW'(mag[i]);
      if (fin.deg) comp[i] = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {comp[2], comp[1], comp[0]};
      m_tuser <= fin.deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= r_valid[ROOT_STEPS];
    end
  end

`ifndef ASSERT_OFF
  // A degenerate result carries a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 48'd0)
    else $error("degenerate result with nonzero normal");

  // Components stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384
      && $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384
      && $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384))
    else $error("normal component out of range");

  // A unit normal has some component of at least 1/sqrt(3)
  a_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      ($signed(m_tdata[15:0]) > 9000 || $signed(m_tdata[15:0]) < -9000
      || $signed(m_tdata[31:16]) > 9000 || $signed(m_tdata[31:16]) < -9000
      || $signed(m_tdata[47:32]) > 9000 || $signed(m_tdata[47:32]) < -9000))
    else $error("normal too short");
`endif
endmodule
`default_nettype wire

@@ test/triangle_face_normal_core_tb.sv @@
// Testbench for triangle_face_normal_core: random and directed triangles, exact predictor.
`timescale 1ns / 100ps
module triangle_face_normal_core_tb;
  import tfn_pkg::*;

  typedef enum logic [1:0] {K_TRI, K_CFG, K_DRAIN} kind_e;

  typedef struct {
    kind_e          kind;
    logic [143:0]   data;
    logic [THW-1:0] thr;
  } pend_t;

  typedef struct {
    logic [47:0] normal;
    logic        deg;
  } normal_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we;
  logic [15:0]  cfg_data;

  pend_t          tri_q[$];
  normal_t        normal_q[$];
  logic [THW-1:0] thr_copy;
  logic           in_fire;
  int             hold_cnt;
  int             settle_cnt;
  int             stall_cnt;
  int             out_cnt;
  int             quiet_cnt;
  int             errors;
  bit             long_stall_done;

  triangle_face_normal_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // rounded |c| * 2^14 / sqrt(s), by bisection on the exact squared inequality
  function automatic logic [15:0] unit_mag(input logic [127:0] csq, input logic [127:0] s);
    logic [127:0] lhs;
    logic [127:0] k;
    logic [127:0] rhs;
    int lo;
    int hi;
    int mid;
    lhs = csq << (2 * NF + 2);
    lo = 0;
    hi = 1 << NF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      k = 2 * mid - 1;
      rhs = k * k * s;
      if (lhs >= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic normal_t face_normal(input logic [143:0] d, input logic [THW-1:0] thr);
    longint       v[9];
    longint       e1[3];
    longint       e2[3];
    longint       n[3];
    logic [127:0] mag;
    logic [127:0] sq[3];
    logic [127:0] s;
    logic [127:0] t;
    logic [15:0]  m;
    normal_t      r;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(d[16*i +: 16]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = v[3+i] - v[i];
      e2[i] = v[6+i] - v[i];
    end
    for (int i = 0; i < 3; i++) begin
      n[i] = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
      mag = (n[i] < 0) ? -n[i] : n[i];
      sq[i] = mag * mag;
    end
    s = sq[0] + sq[1] + sq[2];
    t = thr;
    r.normal = '0;
    r.deg = 1'b1;
    if (s > t * t) begin
      r.deg = 1'b0;
      for (int i = 0; i < 3; i++) begin
        m = unit_mag(sq[i], s);
        r.normal[16*i +: 16] = (n[i] < 0) ? -m : m;
      end
    end
    return r;
  endfunction

  function automatic logic [143:0] pack_tri(input logic [15:0] c[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = c[i];
    return d;
  endfunction

  // random triangle: wide, small near a base point, or collinear
  function automatic logic [143:0] rand_tri(input int mode);
    logic [15:0] c[9];
    logic [15:0] base[3];
    int          sp;
    int          k;
    for (int i = 0; i < 9; i++) c[i] = 16'($urandom);
    if (mode == 1) begin
      sp = 1 << $urandom_range(0, 6);
      for (int i = 0; i < 3; i++) begin
        base[i] = 16'($urandom);
        c[i] = base[i];
        c[3+i] = 16'(base[i] + $urandom_range(0, 2 * sp) - sp);
        c[6+i] = 16'(base[i] + $urandom_range(0, 2 * sp) - sp);
      end
    end else if (mode == 2) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        c[i] = 16'($urandom_range(0, 8000) - 4000);
        c[3+i] = 16'(c[i] + $urandom_range(0, 400) - 200);
        c[6+i] = 16'(c[i] + k * (c[3+i] - c[i]));
      end
    end
    return pack_tri(c);
  endfunction

  task automatic add_tri(input logic [143:0] d);
    pend_t p;
    p.kind = K_TRI;
    p.data = d;
    p.thr = '0;
    tri_q.insert(tri_q.size(), p);
  endtask

  task automatic add_ctl(input kind_e k, input logic [THW-1:0] v);
    pend_t p;
    p.kind = k;
    p.data = '0;
    p.thr = v;
    tri_q.insert(tri_q.size(), p);
  endtask

  task automatic add_random(input int cnt);
    int r;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 9);
      add_tri(rand_tri(r < 6 ? 0 : (r < 9 ? 1 : 2)));
    end
  endtask

  // input acceptance and expected result
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        normal_q.insert(normal_q.size(), face_normal(s_tdata, thr_copy));
    end
  end

  // sender: items, register writes while idle, and drain pauses
  always @(negedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we <= 1'b0;
      hold_cnt <= 0;
      settle_cnt <= 0;
    end else begin
      nv = s_tvalid && !in_fire;
      cfg_we <= 1'b0;
      settle_cnt <= (normal_q.size() == 0 && !nv) ? settle_cnt + 1 : 0;
      if (!nv) begin
        if (hold_cnt > 0) begin
          hold_cnt <= hold_cnt - 1;
        end else if (tri_q.size() > 0) begin
          case (tri_q[0].kind)
            K_TRI: begin
              if ((out_cnt >= 500 && out_cnt < 800) || $urandom_range(0, 99) >= 19) begin
                s_tdata <= tri_q[0].data;
                nv = 1'b1;
                void'(tri_q.pop_front());
              end
            end
            K_CFG: begin
              if (settle_cnt >= 25) begin
                cfg_we <= 1'b1;
                cfg_data <= tri_q[0].thr;
                thr_copy <= tri_q[0].thr;
                void'(tri_q.pop_front());
              end
            end
            default: begin
              if (normal_q.size() == 0 && !in_fire) begin
                hold_cnt <= 10;
                void'(tri_q.pop_front());
              end
            end
          endcase
        end
      end
      s_tvalid <= nv;
    end
  end

  // receiver: random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_cnt <= 0;
      long_stall_done <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_tready <= 1'b0;
    end else if (!long_stall_done && out_cnt == 150) begin
      long_stall_done <= 1'b1;
      stall_cnt <= 200;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (out_cnt >= 500 && out_cnt < 800) || $urandom_range(0, 99) >= 19;
    end
  end

  // result check
  always @(posedge clk) begin
    normal_t e;
    if (!rst && m_tvalid && m_tready) begin
      out_cnt <= out_cnt + 1;
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result normal=%h deg=%b", $realtime, m_tdata, m_tuser);
        errors++;
      end else begin
        e = normal_q.pop_front();
        if (m_tdata !== e.normal) begin
          $display("%0t: normal expected %h actual %h", $realtime, e.normal, m_tdata);
          errors++;
        end
        if (m_tuser !== e.deg) begin
          $display("%0t: degenerate expected %b actual %b", $realtime, e.deg, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item, taken result or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > 3000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] c[9];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    thr_copy = THRESH_RESET;
    errors = 0;
    out_cnt = 0;
    quiet_cnt = 0;

    // extremes: all-minimum, all-maximum, largest spread on each axis
    c = '{default: 16'h8000};
    add_tri(pack_tri(c));
    c = '{default: 16'h7fff};
    add_tri(pack_tri(c));
    c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
          16'h8000, 16'h7fff, 16'h8000};
    add_tri(pack_tri(c));
    c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
          16'h7fff, 16'h7fff, 16'h8000};
    add_tri(pack_tri(c));
    c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h8000, 16'h8000, 16'h7fff};
    add_tri(pack_tri(c));
    // unit axis triangles, full scale components of both signs
    c = '{0, 0, 0, 16'd4096, 0, 0, 0, 16'd4096, 0};
    add_tri(pack_tri(c));
    c = '{0, 0, 0, 0, 16'd4096, 0, 16'd4096, 0, 0};
    add_tri(pack_tri(c));
    c = '{0, 0, 0, 0, 0, 16'd1, 16'd1, 0, 0};
    add_tri(pack_tri(c));
    // cross length right at the threshold of 17 and just above
    c = '{0, 0, 0, 16'd17, 0, 0, 0, 16'd1, 0};
    add_tri(pack_tri(c));
    c = '{0, 0, 0, 16'd18, 0, 0, 0, 16'd1, 0};
    add_tri(pack_tri(c));
    c = '{0, 0, 0, 16'd3, 16'd4, 0, 0, 0, 16'd5};
    add_tri(pack_tri(c));
    add_random(8);

    // zero threshold: zero cross product stays degenerate
    add_ctl(K_CFG, 16'd0);
    c = '{default: 16'd123};
    add_tri(pack_tri(c));
    c = '{0, 0, 0, 16'd1, 0, 0, 0, 16'd1, 0};
    add_tri(pack_tri(c));
    add_random(300);

    // maximum threshold
    add_ctl(K_CFG, 16'hffff);
    c = '{0, 0, 0, 16'd255, 0, 0, 0, 16'd257, 0};
    add_tri(pack_tri(c));
    c = '{0, 0, 0, 16'd256, 0, 0, 0, 16'd256, 0};
    add_tri(pack_tri(c));
    add_random(300);

    add_ctl(K_DRAIN, 0);
    add_ctl(K_CFG, 16'($urandom_range(1, 4000)));
    add_random(300);
    add_ctl(K_CFG, THRESH_RESET);
    add_random(370);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(tri_q.size() == 0 && !s_tvalid && normal_q.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && normal_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/tfn_pkg.sv
rtl/core/tfn_edge_cross.sv
rtl/core/tfn_norm_sq.sv
rtl/core/tfn_root_step.sv
rtl/core/triangle_face_normal_core.sv
test/triangle_face_normal_core_tb.sv
